@@ design/rcpb_pkg.sv @@
// Package for the random cycle permutation builder.
// Holds shared widths, constants, status codes and the controller command/status structs.
// No dependencies.
package rcpb_pkg;

    localparam int unsigned MAX_SLOTS_DEFAULT = 4096;
    localparam int unsigned CNT_W = 13;
    localparam int unsigned SLOT_W = 12;
    localparam int unsigned SEED_W = 64;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;
    localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 13'd64;
    localparam logic [SEED_W-1:0] SEED_RESET = 64'd88172645463325252;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOTBUILT = 2'd2;

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic draw;
        logic div_start;
        logic swap_rd;
        logic swap_wr_k;
        logic swap_wr_r;
        logic succ_rd;
        logic succ_wr;
        logic read_start;
        logic finish_build;
    } rcpb_cmd_t;

    typedef struct packed {
        logic init_done;
        logic div_done;
        logic swap_done;
        logic succ_done;
    } rcpb_sts_t;

endpackage

@@ design/rcpb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcpb_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/rcpb_divider.sv @@
// Bit-serial unsigned remainder of a 64-bit word by a DIV_W-bit divisor, one bit per cycle.
// Depends on rcpb_pkg.
module rcpb_divider #(
    parameter int unsigned DIV_W = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rcpb_pkg::SEED_W-1:0]   dividend,
    input  logic [DIV_W-1:0]              divisor,
    output logic                          done,
    output logic [DIV_W-1:0]              remainder
);
    localparam int unsigned BIT_W = $clog2(rcpb_pkg::SEED_W);

    logic [rcpb_pkg::SEED_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]            rem_reg, rem_next;
    logic [DIV_W-1:0]            dvs_reg, dvs_next;
    logic [BIT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [DIV_W:0]              trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[rcpb_pkg::SEED_W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[rcpb_pkg::SEED_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_W'(rcpb_pkg::SEED_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

@@ design/rcpb_datapath.sv @@
// Datapath: generator, counters, permutation and successor memories, divider and result.
// Depends on rcpb_pkg, rcpb_ram and rcpb_divider.
module rcpb_datapath #(
    parameter int unsigned MAX_SLOTS = rcpb_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rcpb_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [rcpb_pkg::SEED_W-1:0]       cfg_data,
    input  logic [$clog2(MAX_SLOTS)-1:0]      in_slot,
    input  logic                              in_range,
    input  rcpb_pkg::rcpb_cmd_t               cmd,
    output rcpb_pkg::rcpb_sts_t               sts,
    output logic [rcpb_pkg::SLOT_W-1:0]       res_next,
    output logic [1:0]                        res_status
);
    localparam int unsigned AW = $clog2(MAX_SLOTS);
    localparam int unsigned NW = AW + 1;

    logic [rcpb_pkg::CNT_W-1:0]  slot_count_reg;
    logic [rcpb_pkg::SEED_W-1:0] gen_reg;
    logic [NW-1:0]               n_reg, built_reg, k_reg;
    logic [AW-1:0]               r_reg, first_reg, prev_reg;
    logic [AW-1:0]               val_k_reg;
    logic                        ready_reg;
    logic                        read_ok_reg;
    logic [1:0]                  read_st_reg;
    logic [NW-1:0]               n_clamp;
    logic [rcpb_pkg::SEED_W-1:0] x1, x2, x3;
    logic                        div_done;
    logic [NW-1:0]               rem;

    logic          p_we;
    logic [AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic          s_we;
    logic [AW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;

    always_comb begin
        if (slot_count_reg < rcpb_pkg::CNT_W'(2)) begin
            n_clamp = NW'(2);
        end else if (32'(slot_count_reg) > MAX_SLOTS) begin
            n_clamp = NW'(MAX_SLOTS);
        end else begin
            n_clamp = NW'(slot_count_reg);
        end
        x1 = gen_reg ^ (gen_reg << 13);
        x2 = x1 ^ (x1 >> 7);
        x3 = x2 ^ (x2 << 17);
    end

    rcpb_divider #(.DIV_W(NW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (gen_reg),
        .divisor   (k_reg),
        .done      (div_done),
        .remainder (rem)
    );

    // Swap: read perm[r] while perm[k] value is held in val_k_reg.
    always_comb begin
        p_we    = 1'b0;
        p_waddr = k_reg[AW-1:0];
        p_wdata = k_reg[AW-1:0];
        p_raddr = k_reg[AW-1:0];
        if (cmd.init_step) begin
            p_we = 1'b1;
        end else if (cmd.swap_wr_k) begin
            p_we    = 1'b1;
            p_wdata = p_rdata;
        end else if (cmd.swap_wr_r) begin
            p_we    = 1'b1;
            p_waddr = r_reg;
            p_wdata = val_k_reg;
        end
        if (cmd.swap_rd) begin
            p_raddr = r_reg;
        end
        s_we    = cmd.succ_wr;
        s_waddr = prev_reg;
        s_wdata = p_rdata;
        s_raddr = in_slot;
        if (cmd.succ_wr && k_reg == n_reg) begin
            s_wdata = first_reg;
        end
    end

    rcpb_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_perm (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    rcpb_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_succ (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= rcpb_pkg::SLOT_COUNT_RESET;
            gen_reg        <= rcpb_pkg::SEED_RESET;
            ready_reg      <= 1'b0;
            built_reg      <= '0;
        end else begin
            if (cfg_we && cfg_idx == rcpb_pkg::CFG_SLOT_COUNT) begin
                slot_count_reg <= cfg_data[rcpb_pkg::CNT_W-1:0];
            end else if (cfg_we && cfg_idx == rcpb_pkg::CFG_SEED) begin
                gen_reg <= cfg_data;
            end
            if (cmd.draw) begin
                gen_reg <= x3;
            end
            if (cmd.finish_build) begin
                ready_reg <= 1'b1;
                built_reg <= n_reg;
            end
        end
    end

    // Build sequencing: init counts k up, shuffle counts k down, successor pass counts k up.
    always_ff @(posedge aclk) begin
        if (cmd.init_start) begin
            n_reg <= n_clamp;
            k_reg <= '0;
        end else if (cmd.init_step) begin
            if (k_reg == n_reg - 1'b1) begin
                k_reg <= n_reg - 1'b1;
            end else begin
                k_reg <= k_reg + 1'b1;
            end
        end else if (cmd.swap_wr_r) begin
            if (k_reg == NW'(1)) begin
                k_reg <= '0;
            end else begin
                k_reg <= k_reg - 1'b1;
            end
        end else if (cmd.succ_wr) begin
            k_reg <= k_reg + 1'b1;
        end else if (cmd.succ_rd && k_reg == '0) begin
            k_reg <= NW'(1);
        end
        if (div_done) begin
            r_reg <= rem[AW-1:0];
        end
        if (cmd.swap_rd) begin
            val_k_reg <= p_rdata;
        end
        if (cmd.succ_rd && k_reg == '0) begin
            first_reg <= p_rdata;
            prev_reg  <= p_rdata;
        end
        if (cmd.succ_wr) begin
            prev_reg <= p_rdata;
        end
        if (cmd.read_start) begin
            if (!ready_reg) begin
                read_ok_reg <= 1'b0;
                read_st_reg <= rcpb_pkg::ST_NOTBUILT;
            end else if (!in_range || NW'(in_slot) >= built_reg) begin
                read_ok_reg <= 1'b0;
                read_st_reg <= rcpb_pkg::ST_RANGE;
            end else begin
                read_ok_reg <= 1'b1;
                read_st_reg <= rcpb_pkg::ST_OK;
            end
        end else if (cmd.init_start) begin
            read_ok_reg <= 1'b0;
            read_st_reg <= rcpb_pkg::ST_OK;
        end
    end

    assign sts.init_done = (k_reg == n_reg - 1'b1);
    assign sts.div_done  = div_done;
    assign sts.swap_done = (k_reg == NW'(1));
    assign sts.succ_done = (k_reg == n_reg);

    assign res_next   = read_ok_reg ? rcpb_pkg::SLOT_W'(s_rdata) : '0;
    assign res_status = read_st_reg;
endmodule

@@ design/rcpb_ctrl.sv @@
// Controller state machine: sequences builds and reads, owns the stream handshakes.
// Depends on rcpb_pkg.
module rcpb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_load,
    output rcpb_pkg::rcpb_cmd_t  cmd,
    input  rcpb_pkg::rcpb_sts_t  sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_DRAW  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_RDR   = 4'd5;
    localparam logic [3:0] S_WRK   = 4'd6;
    localparam logic [3:0] S_WRR   = 4'd7;
    localparam logic [3:0] S_SRD0  = 4'd8;
    localparam logic [3:0] S_SRD   = 4'd9;
    localparam logic [3:0] S_SWR   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_READ  = 4'd12;
    localparam logic [3:0] S_RKD   = 4'd13;
    localparam logic [3:0] S_SRN   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       busy;
    logic       accept;

    assign busy     = (state_reg != S_IDLE);
    assign in_ready = !busy && (!valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        out_load   = 1'b0;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == rcpb_pkg::OP_BUILD) begin
                        cmd.init_start = 1'b1;
                        state_next     = S_INIT;
                    end else begin
                        cmd.read_start = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_done) begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW: begin
                cmd.draw   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT: begin
                if (sts.div_done) begin
                    state_next = S_RKD;
                end
            end
            S_RKD: begin
                state_next = S_RDR;
            end
            S_RDR: begin
                cmd.swap_rd = 1'b1;
                state_next  = S_WRK;
            end
            S_WRK: begin
                cmd.swap_wr_k = 1'b1;
                state_next    = S_WRR;
            end
            S_WRR: begin
                cmd.swap_wr_r = 1'b1;
                state_next    = sts.swap_done ? S_SRD0 : S_DRAW;
            end
            S_SRD0: begin
                state_next = S_SRD;
            end
            S_SRD: begin
                cmd.succ_rd = 1'b1;
                state_next  = S_SRN;
            end
            S_SRN: begin
                state_next = S_SWR;
            end
            S_SWR: begin
                cmd.succ_wr = 1'b1;
                state_next  = sts.succ_done ? S_DONE : S_SRN;
            end
            S_DONE: begin
                cmd.finish_build = 1'b1;
                out_load         = 1'b1;
                valid_next       = 1'b1;
                state_next       = S_IDLE;
            end
            S_READ: begin
                out_load   = 1'b1;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
endmodule

@@ design/random_cycle_permutation_builder_top.sv @@
// Top level of the random cycle permutation builder.
// Depends on rcpb_pkg, rcpb_ctrl and rcpb_datapath.
//
// A read transfer (opcode 1) reads the successor memory through its registered read port, and
// its result is then loaded into the output register; no new item is accepted until the
// controller is idle again. A build transfer (opcode 0) for n slots runs the initialisation,
// a shuffle of n-1 swaps and the successor pass before its result, each swap using the
// bit-serial 64-bit remainder unit (one bit per cycle) once. A
// result waits in an output register, and a new item is accepted only while that register
// is empty or is being emptied in the same cycle.
module random_cycle_permutation_builder_top #(
    parameter int unsigned MAX_SLOTS = rcpb_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // opcode, slot_index
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,  // next_slot, status
    input  logic                               cfg_we,
    input  logic [rcpb_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [rcpb_pkg::SEED_W-1:0]        cfg_data
);
    localparam int unsigned AW = $clog2(MAX_SLOTS);

    rcpb_pkg::rcpb_cmd_t          cmd;
    rcpb_pkg::rcpb_sts_t          sts;
    logic                         out_load;
    logic [rcpb_pkg::SLOT_W-1:0]  res_next;
    logic [1:0]                   res_status;
    logic [15:0]                  tdata_reg;
    logic [AW-1:0]                in_slot;
    logic                         in_range;

    assign in_range = (32'(s_tdata[12:1]) < MAX_SLOTS);
    assign in_slot  = AW'(s_tdata[12:1]);

    rcpb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_load  (out_load),
        .cmd       (cmd),
        .sts       (sts)
    );

    rcpb_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_slot    (in_slot),
        .in_range   (in_range),
        .cmd        (cmd),
        .sts        (sts),
        .res_next   (res_next),
        .res_status (res_status)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            tdata_reg <= {2'b00, res_status, res_next};
        end
    end

    assign m_tdata = tdata_reg;
endmodule

@@ sim/perm_checker.sv @@
`timescale 1ns / 100ps
// Checker for the random cycle permutation builder: predicts each result from observed transfers
// and register writes, then compares it with the result channel. Depends on rcpb_pkg.
module perm_checker
    import rcpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [SEED_W-1:0]    cfg_data,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] next_slot;
    } reply_t;

    reply_t            replies_due[$];
    logic [CNT_W-1:0]  count_reg;
    logic [SEED_W-1:0] xs_word;
    logic [SLOT_W-1:0] order[MAX_SLOTS_DEFAULT];
    logic [SLOT_W-1:0] succ[MAX_SLOTS_DEFAULT];
    bit                table_built;
    int unsigned       built_n;

    function automatic logic [SEED_W-1:0] xorshift_next(logic [SEED_W-1:0] x);
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    function void build_cycle_table();
        int unsigned n;
        int unsigned r;
        logic [SLOT_W-1:0] t;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > MAX_SLOTS_DEFAULT) n = MAX_SLOTS_DEFAULT;
        for (int unsigned k = 0; k < n; k++) order[k] = k[SLOT_W-1:0];
        for (int unsigned k = n - 1; k > 0; k--) begin
            xs_word = xorshift_next(xs_word);
            r = int'(xs_word % 64'(k));
            t = order[k];
            order[k] = order[r];
            order[r] = t;
        end
        for (int unsigned k = 0; k < n; k++) begin
            succ[order[k]] = order[(k + 1 == n) ? 0 : k + 1];
        end
        built_n = n;
        table_built = 1'b1;
    endfunction

    function reply_t predict_reply(logic op, logic [SLOT_W-1:0] slot);
        reply_t r;
        r = '0;
        if (op == OP_BUILD) begin
            build_cycle_table();
        end else if (!table_built) begin
            r.status = ST_NOTBUILT;
        end else if (slot >= built_n) begin
            r.status = ST_RANGE;
        end else begin
            r.next_slot = succ[slot];
        end
        return r;
    endfunction

    initial errors = 0;

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            count_reg = SLOT_COUNT_RESET;
            xs_word = SEED_RESET;
            table_built = 1'b0;
            built_n = 0;
            replies_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_SLOT_COUNT) begin
                    count_reg = cfg_data[CNT_W-1:0];
                end else if (cfg_idx == CFG_SEED) begin
                    xs_word = cfg_data;
                end
            end
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result transfer with no prediction waiting: %h", m_tdata);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[11:0] !== want.next_slot) begin
                        $error("next_slot expected %0d actual %0d", want.next_slot,
                               m_tdata[11:0]);
                        errors++;
                    end
                    if (m_tdata[13:12] !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tdata[13:12]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                replies_due.push_back(predict_reply(s_tdata[0], s_tdata[12:1]));
            end
        end
        pending = replies_due.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Top of the testbench: drives register writes, build and read transfers with varied idling,
// and reports the verdict. Depends on rcpb_pkg, perm_checker and the design top.
module testbench;
    import rcpb_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [SEED_W-1:0]    cfg_data = '0;
    int                   errors;
    int                   pending;
    int                   idle_mode = 0;
    int unsigned          cur_n = 0;
    int unsigned          count_val = 64;
    longint               cycles = 0;

    always #1 aclk = ~aclk;

    random_cycle_permutation_builder_top dut (.*);

    perm_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (idle_mode == 2) m_tready <= ($urandom_range(99) >= 74);
        else if (idle_mode == 3) m_tready <= ($urandom_range(99) >= 10);
        else m_tready <= 1'b1;
    end

    task automatic send_item(logic op, logic [SLOT_W-1:0] slot);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 74 : (idle_mode == 3) ? 10 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, slot, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (op == OP_BUILD) begin
            cur_n = (count_val < 2) ? 2 : (count_val > 4096) ? 4096 : count_val;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [SEED_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLOT_COUNT) count_val = 32'(value[CNT_W-1:0]);
    endtask

    task automatic random_read();
        logic [SLOT_W-1:0] slot;
        if (cur_n != 0 && $urandom_range(99) < 80) slot = SLOT_W'($urandom_range(cur_n - 1));
        else slot = SLOT_W'($urandom_range(4095));
        send_item(OP_READ, slot);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(OP_READ, 12'd0);
        send_item(OP_READ, 12'd4095);
        send_item(OP_BUILD, 12'd4095);
        send_item(OP_READ, 12'd0);
        send_item(OP_READ, 12'd63);
        send_item(OP_READ, 12'd64);
        send_item(OP_READ, 12'd4095);
        drain();
        set_reg(CFG_SLOT_COUNT, 64'd0);
        send_item(OP_BUILD, 12'd0);
        send_item(OP_READ, 12'd0);
        send_item(OP_READ, 12'd1);
        send_item(OP_READ, 12'd2);
        drain();
        set_reg(CFG_SLOT_COUNT, 64'd1);
        set_reg(CFG_SEED, 64'd0);
        send_item(OP_BUILD, 12'd0);
        drain();
        set_reg(CFG_SLOT_COUNT, 64'd5);
        send_item(OP_BUILD, 12'd0);
        for (int i = 0; i < 5; i++) send_item(OP_READ, i[SLOT_W-1:0]);
        drain();
        set_reg(CFG_SLOT_COUNT, 64'd100);
        send_item(OP_READ, 12'd4);
        send_item(OP_READ, 12'd50);
        drain();
        set_reg(CFG_SLOT_COUNT, 64'd8191);
        set_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_BUILD, 12'd0);
        for (int i = 0; i < 40; i++) random_read();
        send_item(OP_READ, 12'd4095);
        drain();

        for (int m = 0; m < 4; m++) begin
            idle_mode = m;
            for (int s = 0; s < 5; s++) begin
                drain();
                set_reg(CFG_SLOT_COUNT, (s == 0) ? 64'd2 : 64'($urandom_range(2, 64)));
                set_reg(CFG_SEED, ($urandom_range(19) == 0) ? 64'd0 : {$urandom, $urandom});
                send_item(OP_BUILD, SLOT_W'($urandom_range(4095)));
                for (int i = 0; i < 60; i++) begin
                    if ($urandom_range(49) == 0) send_item(OP_BUILD, SLOT_W'($urandom_range(4095)));
                    else random_read();
                end
            end
            idle_mode = (m == 3) ? 0 : m;
        end
        drain();
        idle_mode = 0;
        repeat (20) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ random_cycle_permutation_builder_top.f @@
design/rcpb_pkg.sv
design/rcpb_ram.sv
design/rcpb_divider.sv
design/rcpb_datapath.sv
design/rcpb_ctrl.sv
design/random_cycle_permutation_builder_top.sv
sim/perm_checker.sv
sim/testbench.sv
